// ----- rtl/core/bma_pkg.sv -----
// bma_pkg: shared widths, divider constants, reset values, register codes and divider request type
// for the boxcar moving average block; no dependencies
package bma_pkg;

  localparam int SAMPLE_W  = 32;
  localparam int WSIZE_W   = 8;
  localparam int SUM_W     = 40;
  localparam int ADDR_W    = 3;
  localparam int DATA_W    = 32;

  // quotient bits retired per divider pass
  localparam int DIV_STEPS  = 4;
  localparam int DIV_CYCLES = SUM_W / DIV_STEPS;
  localparam int DIV_CNT_W  = $clog2(DIV_CYCLES);

  localparam logic [WSIZE_W-1:0]  WSIZE_RESET = 8'd128;
  localparam logic [SAMPLE_W-1:0] FILL_RESET  = 32'd0;

  typedef enum logic [0:0] {
    REG_WINDOW_SIZE = 1'b0,
    REG_FILL_WORD   = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic signed [SUM_W-1:0] dividend;
    logic [WSIZE_W-1:0]      divisor;
  } div_req_t;

endpackage

// ----- rtl/core/bma_sample_if.sv -----
// bma_sample_if: valid/ready channel carrying one input sample
// depends on bma_pkg
interface bma_sample_if;
  import bma_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

// ----- rtl/core/bma_average_if.sv -----
// bma_average_if: valid/ready channel carrying one average result
// depends on bma_pkg
interface bma_average_if;
  import bma_pkg::*;

  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] average;

  modport source (output valid, output average, input ready);
  modport sink   (input valid, input average, output ready);
endinterface

// ----- rtl/core/bma_cell.sv -----
// bma_cell: one slot of the sample delay line
// loads the fill value, takes the new sample or passes its neighbor's value down
// depends on bma_pkg
module bma_cell (
  input  logic                       clk,
  input  logic                       load,
  input  logic                       shift,
  input  logic                       inject,
  input  logic signed [bma_pkg::SAMPLE_W-1:0] fill,
  input  logic signed [bma_pkg::SAMPLE_W-1:0] sample,
  input  logic signed [bma_pkg::SAMPLE_W-1:0] from_next,
  output logic signed [bma_pkg::SAMPLE_W-1:0] q
);
  import bma_pkg::*;

  always_ff @(posedge clk) begin
    if (load) begin
      q <= fill;
    end else if (shift) begin
      q <= inject ? sample : from_next;
    end
  end

endmodule

// ----- rtl/core/bma_div.sv -----
// bma_div: iterative signed-by-unsigned divider, truncates toward zero
// restoring divide, DIV_STEPS quotient bits per cycle; depends on bma_pkg
module bma_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  bma_pkg::div_req_t                   req,
  output logic                                idle,
  output logic                                res_valid,
  input  logic                                res_ready,
  output logic signed [bma_pkg::SAMPLE_W-1:0] quotient
);
  import bma_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_DONE = 3'b100
  } div_state_t;

  div_state_t           state;
  logic [DIV_CNT_W-1:0] cnt;
  logic [SUM_W-1:0]     dvd;
  logic [SUM_W-1:0]     quo;
  logic [WSIZE_W-1:0]   rem;
  logic [WSIZE_W-1:0]   dsr;
  logic                 neg;

  logic [SUM_W-1:0]     mag;
  logic [SUM_W-1:0]     dvd_next;
  logic [SUM_W-1:0]     quo_next;
  logic [WSIZE_W-1:0]   rem_next;
  logic [WSIZE_W:0]     trial;
  logic [SAMPLE_W-1:0]  quo_lo;

  assign mag = req.dividend[SUM_W-1] ? ((~req.dividend) + SUM_W'(1)) : req.dividend;

  // DIV_STEPS restoring steps on a narrow remainder
  always_comb begin
    rem_next = rem;
    dvd_next = dvd;
    quo_next = quo;
    trial    = '0;
    for (int k = 0; k < DIV_STEPS; k++) begin
      trial    = {rem_next, dvd_next[SUM_W-1]};
      dvd_next = {dvd_next[SUM_W-2:0], 1'b0};
      if (trial >= {1'b0, dsr}) begin
        trial    = trial - {1'b0, dsr};
        quo_next = {quo_next[SUM_W-2:0], 1'b1};
      end else begin
        quo_next = {quo_next[SUM_W-2:0], 1'b0};
      end
      rem_next = trial[WSIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_RUN;
            cnt   <= '0;
          end
        end
        ST_RUN: begin
          cnt <= cnt + DIV_CNT_W'(1);
          if (cnt == DIV_CNT_W'(DIV_CYCLES - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && start) begin
      dvd <= mag;
      quo <= '0;
      rem <= '0;
      dsr <= req.divisor;
      neg <= req.dividend[SUM_W-1];
    end else if (state == ST_RUN) begin
      dvd <= dvd_next;
      quo <= quo_next;
      rem <= rem_next;
    end
  end

  assign quo_lo    = quo[SAMPLE_W-1:0];
  assign quotient  = neg ? ((~quo_lo) + SAMPLE_W'(1)) : quo_lo;
  assign idle      = (state == ST_IDLE);
  assign res_valid = (state == ST_DONE);

endmodule

// ----- rtl/core/boxcar_moving_average.sv -----
// boxcar_moving_average: running mean of the last window_size signed samples
// a taken sample starts the iterative divider, whose result then loads the output register;
// no new sample is taken until the divider has handed its last result on
// reset: window_size 128, fill word 0; one refill cycle follows reset and
// every register write, and no sample is taken during it
// depends on bma_pkg, bma_sample_if, bma_average_if, bma_cell, bma_div
module boxcar_moving_average #(
  parameter int MAX_WINDOW = 128
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [bma_pkg::ADDR_W-1:0]   paddr,
  input  logic [bma_pkg::DATA_W-1:0]   pwdata,
  output logic [bma_pkg::DATA_W-1:0]   prdata,
  output logic                         pready,
  bma_sample_if.sink                   sample_chan,
  bma_average_if.source                average_chan
);
  import bma_pkg::*;

  localparam logic [WSIZE_W-1:0] MAX_N = WSIZE_W'(MAX_WINDOW);

  // ---------------------------------------------------------------
  // register file
  // ---------------------------------------------------------------
  logic [WSIZE_W-1:0]         window_size;
  logic signed [SAMPLE_W-1:0] fill_word;
  logic                       refill;
  logic                       cfg_wr;
  reg_idx_t                   cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  // register index is the word address; the low byte bits are don't-care
  assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WSIZE_RESET;
      fill_word   <= FILL_RESET;
      refill      <= 1'b1;
    end else begin
      refill <= cfg_wr;
      if (cfg_wr) begin
        case (cfg_idx)
          REG_WINDOW_SIZE: window_size <= pwdata[WSIZE_W-1:0];
          REG_FILL_WORD:   fill_word   <= pwdata[SAMPLE_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_WINDOW_SIZE: prdata = {{(DATA_W-WSIZE_W){1'b0}}, window_size};
      REG_FILL_WORD:   prdata = fill_word;
      default:         prdata = '0;
    endcase
  end

  // effective window: zero acts as one, anything past the line length saturates
  logic [WSIZE_W-1:0] n_eff;
  logic [WSIZE_W-1:0] last_slot;

  always_comb begin
    if (window_size == '0) begin
      n_eff = WSIZE_W'(1);
    end else if (window_size > MAX_N) begin
      n_eff = MAX_N;
    end else begin
      n_eff = window_size;
    end
  end

  assign last_slot = n_eff - WSIZE_W'(1);

  // ---------------------------------------------------------------
  // input handshake
  // ---------------------------------------------------------------
  logic div_idle;
  logic accept;

  // samples wait while the window refills or the divider is occupied
  assign sample_chan.ready = !refill && div_idle;
  assign accept            = sample_chan.valid && sample_chan.ready;

  // ---------------------------------------------------------------
  // sample delay line
  // the new sample enters at slot n-1 and every slot below moves one step
  // toward slot 0, so slot 0 always holds the sample leaving the window;
  // slots at n and above never reach slot 0 and just drift
  // ---------------------------------------------------------------
  logic signed [SAMPLE_W-1:0] cell_q   [MAX_WINDOW];
  logic signed [SAMPLE_W-1:0] cell_nxt [MAX_WINDOW];

  for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
    if (g == MAX_WINDOW - 1) begin : g_tail
      assign cell_nxt[g] = fill_word;
    end else begin : g_body
      assign cell_nxt[g] = cell_q[g+1];
    end

    bma_cell u_cell (
      .clk       (clk),
      .load      (refill),
      .shift     (accept),
      .inject    (last_slot == WSIZE_W'(g)),
      .fill      (fill_word),
      .sample    (sample_chan.sample),
      .from_next (cell_nxt[g]),
      .q         (cell_q[g])
    );
  end

  // ---------------------------------------------------------------
  // running sum
  // ---------------------------------------------------------------
  logic signed [SUM_W-1:0]           running_sum;
  logic signed [SUM_W-1:0]           sum_next;
  logic signed [SUM_W-1:0]           old_ext;
  logic signed [SUM_W-1:0]           new_ext;
  logic signed [WSIZE_W:0]           n_signed;
  logic signed [WSIZE_W+SAMPLE_W:0]  fill_prod;

  assign old_ext   = {{(SUM_W-SAMPLE_W){cell_q[0][SAMPLE_W-1]}}, cell_q[0]};
  assign new_ext   = {{(SUM_W-SAMPLE_W){sample_chan.sample[SAMPLE_W-1]}},
                      sample_chan.sample};
  assign sum_next  = running_sum - old_ext + new_ext;

  // refill total is n * fill; 41-bit product, the top bit is only sign copy
  assign n_signed  = {1'b0, n_eff};
  assign fill_prod = n_signed * fill_word;

  always_ff @(posedge clk) begin
    if (refill) begin
      running_sum <= fill_prod[SUM_W-1:0];
    end else if (accept) begin
      running_sum <= sum_next;
    end
  end

  // ---------------------------------------------------------------
  // divide by the window size
  // ---------------------------------------------------------------
  div_req_t                   div_req;
  logic                       div_res_valid;
  logic                       div_res_ready;
  logic signed [SAMPLE_W-1:0] div_quotient;

  assign div_req.dividend = sum_next;
  assign div_req.divisor  = n_eff;

  bma_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .req       (div_req),
    .idle      (div_idle),
    .res_valid (div_res_valid),
    .res_ready (div_res_ready),
    .quotient  (div_quotient)
  );

  // ---------------------------------------------------------------
  // output register
  // ---------------------------------------------------------------
  logic out_load;

  assign div_res_ready = !average_chan.valid || average_chan.ready;
  assign out_load      = div_res_valid && div_res_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      average_chan.valid <= 1'b0;
    end else if (out_load) begin
      average_chan.valid <= 1'b1;
    end else if (average_chan.ready) begin
      average_chan.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average_chan.average <= div_quotient;
    end
  end

`ifndef SYNTH
  // the divider holds off the next request right after one is taken
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !sample_chan.ready)
    else $error("sample taken while divider still busy");

  // a register write is always followed by a refill cycle
  a_refill_after_write: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> refill)
    else $error("register write without refill");

  // refill sets the sum to window size times fill word
  a_refill_sum: assert property (@(posedge clk) disable iff (rst)
    refill |=> running_sum == $past(fill_prod[SUM_W-1:0]))
    else $error("running sum wrong after refill");

  // effective window stays within the delay line
  a_window_range: assert property (@(posedge clk) disable iff (rst)
    n_eff != '0 && n_eff <= MAX_N)
    else $error("effective window out of range");
`endif

endmodule
